@@ rtl/core/aarm_pkg.sv @@
// Shared types, constants and helper functions for the axis-angle rotation matrix core.
package aarm_pkg;

    // CORDIC iteration count (8 to 30)
    localparam int CORDIC_STEPS = 16;

    // normalizer: one root bit per sqrt stage, one quotient bit per divide stage
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 29;
    localparam int NORM_LAT  = 1 + SQ_STEPS + DIV_STEPS;
    localparam int CS_DELAY  = NORM_LAT - CORDIC_STEPS;
    localparam int POST_LAT  = 3;
    localparam int TOTAL_LAT = 1 + NORM_LAT + POST_LAT;

    localparam logic signed [31:0] Q28_ONE         = 32'sd268435456;
    localparam logic signed [31:0] Q28_PI          = 32'sd843314857;
    localparam logic signed [31:0] Q28_HALF_PI     = 32'sd421657428;
    localparam logic signed [31:0] CORDIC_INV_GAIN = 32'sd163008218;
    localparam logic signed [15:0] OUT_ONE         = 16'sd16384;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic signed [31:0] z;
    } cordic_in_t;

    typedef struct packed {
        logic              valid;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } cordic_out_t;

    typedef struct packed {
        logic             valid;
        logic [2:0][30:0] sq;
        logic [2:0][15:0] mag;
        logic [2:0]       neg;
    } norm_in_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [2:0][29:0] u;
    } norm_out_t;

    // arctangent of 2^-i in Q.28
    function automatic logic signed [31:0] cordic_atan(input int i);
        logic signed [31:0] v;
        begin
            v = 32'sd0;
            case (i)
                0: v = 32'sd210828714;
                1: v = 32'sd124459457;
                2: v = 32'sd65760959;
                3: v = 32'sd33381290;
                4: v = 32'sd16755422;
                5: v = 32'sd8385879;
                6: v = 32'sd4193963;
                7: v = 32'sd2097109;
                8: v = 32'sd1048571;
                9: v = 32'sd524287;
                default: v = (i < 29) ? (Q28_ONE >>> i) : 32'sd0;
            endcase
            return v;
        end
    endfunction

    // round Q.28 to Q1.14 and clamp to plus or minus one
    function automatic logic signed [15:0] to_out(input logic signed [33:0] v);
        logic signed [34:0] sum;
        logic signed [20:0] o;
        logic signed [15:0] r;
        begin
            sum = 35'(v) + 35'sd8192;
            o   = 21'(sum >>> 14);
            if (o > 21'(OUT_ONE))
                r = OUT_ONE;
            else if (o < -21'(OUT_ONE))
                r = -OUT_ONE;
            else
                r = 16'(o);
            return r;
        end
    endfunction

endpackage

@@ rtl/core/aarm_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cos and sin in Q.28, one stage per iteration.
module aarm_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  aarm_pkg::cordic_in_t  cin,
    output aarm_pkg::cordic_out_t cout
);

    localparam int N = aarm_pkg::CORDIC_STEPS;

    logic               vld_reg [0:N-1];
    logic               neg_reg [0:N-1];
    logic signed [31:0] x_reg   [0:N-1];
    logic signed [31:0] y_reg   [0:N-1];
    logic signed [31:0] z_reg   [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic               vld_src;
            logic               neg_src;
            logic signed [31:0] x_src;
            logic signed [31:0] y_src;
            logic signed [31:0] z_src;
            logic signed [31:0] x_next;
            logic signed [31:0] y_next;
            logic signed [31:0] z_next;

            if (k == 0) begin : g_first
                assign vld_src = cin.valid;
                assign neg_src = cin.neg;
                assign x_src   = aarm_pkg::CORDIC_INV_GAIN;
                assign y_src   = 32'sd0;
                assign z_src   = cin.z;
            end else begin : g_rest
                assign vld_src = vld_reg[k-1];
                assign neg_src = neg_reg[k-1];
                assign x_src   = x_reg[k-1];
                assign y_src   = y_reg[k-1];
                assign z_src   = z_reg[k-1];
            end

            // micro-rotation toward z = 0
            always_comb
            begin
                if (z_src >= 0)
                begin
                    x_next = x_src - (y_src >>> k);
                    y_next = y_src + (x_src >>> k);
                    z_next = z_src - aarm_pkg::cordic_atan(k);
                end
                else
                begin
                    x_next = x_src + (y_src >>> k);
                    y_next = y_src - (x_src >>> k);
                    z_next = z_src + aarm_pkg::cordic_atan(k);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else
                    vld_reg[k] <= vld_src;
            end

            always_ff @(posedge clk)
            begin
                neg_reg[k] <= neg_src;
                x_reg[k]   <= x_next;
                y_reg[k]   <= y_next;
                z_reg[k]   <= z_next;
            end
        end
    endgenerate

    // undo the half-turn fold
    assign cout.valid = vld_reg[N-1];
    assign cout.c     = neg_reg[N-1] ? -x_reg[N-1] : x_reg[N-1];
    assign cout.s     = neg_reg[N-1] ? -y_reg[N-1] : y_reg[N-1];

endmodule

@@ rtl/core/aarm_norm.sv @@
// Axis normalizer: squared length, pipelined square root, then three pipelined dividers.
module aarm_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  aarm_pkg::norm_in_t  nin,
    output aarm_pkg::norm_out_t nout
);

    localparam int SQ = aarm_pkg::SQ_STEPS;
    localparam int DV = aarm_pkg::DIV_STEPS;

    // sqrt pipeline, index 0 holds the squared length
    logic             sq_vld_reg  [0:SQ];
    logic             sq_zero_reg [0:SQ];
    logic [31:0]      sq_l2_reg   [0:SQ];
    logic [33:0]      sq_rem_reg  [0:SQ];
    logic [31:0]      sq_root_reg [0:SQ];
    logic [2:0][15:0] sq_mag_reg  [0:SQ];
    logic [2:0]       sq_neg_reg  [0:SQ];

    // divide pipeline
    logic             dv_vld_reg  [0:DV-1];
    logic             dv_zero_reg [0:DV-1];
    logic [31:0]      dv_r_reg    [0:DV-1];
    logic [2:0][31:0] dv_rem_reg  [0:DV-1];
    logic [2:0][28:0] dv_low_reg  [0:DV-1];
    logic [2:0][28:0] dv_q_reg    [0:DV-1];
    logic [2:0]       dv_neg_reg  [0:DV-1];

    // squared length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else
            sq_vld_reg[0] <= nin.valid;
    end

    always_ff @(posedge clk)
    begin
        sq_l2_reg[0]   <= 32'(nin.sq[0]) + 32'(nin.sq[1]) + 32'(nin.sq[2]);
        sq_zero_reg[0] <= (nin.sq[0] == '0) && (nin.sq[1] == '0) && (nin.sq[2] == '0);
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_mag_reg[0]  <= nin.mag;
        sq_neg_reg[0]  <= nin.neg;
    end

    genvar k, l;
    generate
        // one root bit per stage; radicand is l2 * 2^32
        for (k = 0; k < SQ; k++) begin : g_sq
            logic [1:0]  pair;
            logic [35:0] t;
            logic [35:0] trial;
            logic        ge;

            if (k < 16) begin : g_hi
                assign pair = sq_l2_reg[k][31-2*k -: 2];
            end else begin : g_lo
                assign pair = 2'b00;
            end

            always_comb
            begin
                t     = {sq_rem_reg[k], pair};
                trial = {2'b00, sq_root_reg[k], 2'b01};
                ge    = (t >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_vld_reg[k+1] <= 1'b0;
                else
                    sq_vld_reg[k+1] <= sq_vld_reg[k];
            end

            always_ff @(posedge clk)
            begin
                sq_rem_reg[k+1]  <= ge ? 34'(t - trial) : 34'(t);
                sq_root_reg[k+1] <= {sq_root_reg[k][30:0], ge};
                sq_l2_reg[k+1]   <= sq_l2_reg[k];
                sq_zero_reg[k+1] <= sq_zero_reg[k];
                sq_mag_reg[k+1]  <= sq_mag_reg[k];
                sq_neg_reg[k+1]  <= sq_neg_reg[k];
            end
        end

        // one quotient bit per stage; dividend is mag * 2^44 + r / 2
        for (k = 0; k < DV; k++) begin : g_dv
            logic             vld_src;
            logic             zero_src;
            logic [31:0]      r_src;
            logic [2:0][31:0] rem_src;
            logic [2:0][28:0] low_src;
            logic [2:0][28:0] q_src;
            logic [2:0]       neg_src;
            logic [2:0][31:0] rem_next;
            logic [2:0]       ge;

            if (k == 0) begin : g_first
                assign vld_src  = sq_vld_reg[SQ];
                assign zero_src = sq_zero_reg[SQ];
                assign r_src    = sq_root_reg[SQ];
                assign neg_src  = sq_neg_reg[SQ];
                for (l = 0; l < 3; l++) begin : g_init
                    assign rem_src[l] = {1'b0, sq_mag_reg[SQ][l], 13'b0, sq_root_reg[SQ][31:30]};
                    assign low_src[l] = sq_root_reg[SQ][29:1];
                    assign q_src[l]   = '0;
                end
            end else begin : g_rest
                assign vld_src  = dv_vld_reg[k-1];
                assign zero_src = dv_zero_reg[k-1];
                assign r_src    = dv_r_reg[k-1];
                assign neg_src  = dv_neg_reg[k-1];
                assign rem_src  = dv_rem_reg[k-1];
                assign low_src  = dv_low_reg[k-1];
                assign q_src    = dv_q_reg[k-1];
            end

            // trial subtract per lane
            always_comb
            begin
                for (int j = 0; j < 3; j++)
                begin
                    logic [32:0] t;
                    t     = {rem_src[j], low_src[j][28]};
                    ge[j] = (t >= {1'b0, r_src});
                    rem_next[j] = ge[j] ? 32'(t - {1'b0, r_src}) : 32'(t);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_vld_reg[k] <= 1'b0;
                else
                    dv_vld_reg[k] <= vld_src;
            end

            always_ff @(posedge clk)
            begin
                dv_zero_reg[k] <= zero_src;
                dv_r_reg[k]    <= r_src;
                dv_neg_reg[k]  <= neg_src;
                dv_rem_reg[k]  <= rem_next;
                for (int j = 0; j < 3; j++)
                begin
                    dv_low_reg[k][j] <= {low_src[j][27:0], 1'b0};
                    dv_q_reg[k][j]   <= {q_src[j][27:0], ge[j]};
                end
            end
        end
    endgenerate

    // reapply axis signs
    always_comb
    begin
        nout.valid = dv_vld_reg[DV-1];
        nout.zero  = dv_zero_reg[DV-1];
        for (int j = 0; j < 3; j++)
        begin
            if (dv_neg_reg[DV-1][j])
                nout.u[j] = -{1'b0, dv_q_reg[DV-1][j]};
            else
                nout.u[j] = {1'b0, dv_q_reg[DV-1][j]};
        end
    end

endmodule

@@ rtl/core/axis_angle_rotation_matrix_core.sv @@
// Top level: Rodrigues 3x3 rotation matrix from an angle and an unnormalized axis.
//
// Takes one request per clock (busy is always low) and returns the nine Q1.14 elements
// on a one-cycle done strobe; the receiver cannot stall. The latency is set by the
// normalizer: one input stage, a squared-length stage, 32 square-root stages and
// 29 divide stages, followed by three matrix stages (axis products, scaling by
// 1 - cos, rounding and clamping). The CORDIC runs alongside and its cos/sin are
// delayed to line up. A zero-length axis returns the identity matrix.
module axis_angle_rotation_matrix_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [14:0] angle,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    output logic               done,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    localparam int D = aarm_pkg::CS_DELAY;

    logic accept;

    aarm_pkg::cordic_in_t  cin_reg;
    aarm_pkg::cordic_out_t cord_out;
    aarm_pkg::norm_in_t    nin_reg;
    aarm_pkg::norm_out_t   norm_out;

    aarm_pkg::cordic_in_t cin_next;
    aarm_pkg::norm_in_t   nin_next;

    logic signed [31:0] dl_c_reg [0:D-1];
    logic signed [31:0] dl_s_reg [0:D-1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input stage: angle fold, axis squares and magnitudes
    always_comb
    begin
        logic signed [31:0] z;
        z = {angle[14], angle, 16'b0};
        if (z > aarm_pkg::Q28_HALF_PI)
        begin
            cin_next.z   = z - aarm_pkg::Q28_PI;
            cin_next.neg = 1'b1;
        end
        else if (z < -aarm_pkg::Q28_HALF_PI)
        begin
            cin_next.z   = z + aarm_pkg::Q28_PI;
            cin_next.neg = 1'b1;
        end
        else
        begin
            cin_next.z   = z;
            cin_next.neg = 1'b0;
        end
        cin_next.valid = accept;
    end

    always_comb
    begin
        logic signed [15:0] a [0:2];
        logic signed [31:0] p;
        a[0] = axis_x;
        a[1] = axis_y;
        a[2] = axis_z;
        nin_next.valid = accept;
        for (int j = 0; j < 3; j++)
        begin
            p = a[j] * a[j];
            nin_next.sq[j]  = 31'(p);
            nin_next.neg[j] = a[j][15];
            nin_next.mag[j] = a[j][15] ? 16'(-17'(a[j])) : 16'(a[j]);
        end
    end

    // input registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cin_reg <= '0;
            nin_reg <= '0;
        end
        else
        begin
            cin_reg <= cin_next;
            nin_reg <= nin_next;
        end
    end

    aarm_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cin   (cin_reg),
        .cout  (cord_out)
    );

    aarm_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .nin   (nin_reg),
        .nout  (norm_out)
    );

    // line cos/sin up with the normalizer output
    always_ff @(posedge clk)
    begin
        dl_c_reg[0] <= cord_out.c;
        dl_s_reg[0] <= cord_out.s;
        for (int j = 1; j < D; j++)
        begin
            dl_c_reg[j] <= dl_c_reg[j-1];
            dl_s_reg[j] <= dl_s_reg[j-1];
        end
    end

    // stage P1: axis products and axis times sin
    logic               p1_vld_reg;
    logic               p1_zero_reg;
    logic signed [31:0] p1_c_reg;
    logic signed [32:0] p1_omc_reg;
    logic signed [31:0] p1_uu_reg [0:5];
    logic signed [31:0] p1_us_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else
            p1_vld_reg <= norm_out.valid;
    end

    always_ff @(posedge clk)
    begin
        logic signed [29:0] ux, uy, uz;
        ux = $signed(norm_out.u[0]);
        uy = $signed(norm_out.u[1]);
        uz = $signed(norm_out.u[2]);
        p1_zero_reg  <= norm_out.zero;
        p1_c_reg     <= dl_c_reg[D-1];
        p1_omc_reg   <= 33'(aarm_pkg::Q28_ONE) - 33'(dl_c_reg[D-1]);
        p1_uu_reg[0] <= 32'((60'(ux) * 60'(ux)) >>> 28);
        p1_uu_reg[1] <= 32'((60'(uy) * 60'(uy)) >>> 28);
        p1_uu_reg[2] <= 32'((60'(uz) * 60'(uz)) >>> 28);
        p1_uu_reg[3] <= 32'((60'(ux) * 60'(uy)) >>> 28);
        p1_uu_reg[4] <= 32'((60'(ux) * 60'(uz)) >>> 28);
        p1_uu_reg[5] <= 32'((60'(uy) * 60'(uz)) >>> 28);
        p1_us_reg[0] <= 32'((62'(ux) * 62'(dl_s_reg[D-1])) >>> 28);
        p1_us_reg[1] <= 32'((62'(uy) * 62'(dl_s_reg[D-1])) >>> 28);
        p1_us_reg[2] <= 32'((62'(uz) * 62'(dl_s_reg[D-1])) >>> 28);
    end

    // stage P2: scale by 1 - cos
    logic               p2_vld_reg;
    logic               p2_zero_reg;
    logic signed [31:0] p2_c_reg;
    logic signed [31:0] p2_t_reg  [0:5];
    logic signed [31:0] p2_us_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_vld_reg <= 1'b0;
        else
            p2_vld_reg <= p1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        p2_zero_reg <= p1_zero_reg;
        p2_c_reg    <= p1_c_reg;
        for (int j = 0; j < 6; j++)
            p2_t_reg[j] <= 32'((65'(p1_uu_reg[j]) * 65'(p1_omc_reg)) >>> 28);
        for (int j = 0; j < 3; j++)
            p2_us_reg[j] <= p1_us_reg[j];
    end

    // stage P3: sums, rounding, clamp; zero axis gives identity
    logic done_reg;
    logic signed [15:0] m_reg [0:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= p2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [33:0] c, xx, yy, zz, xy, xz, yz, xs, ys, zs;
        c  = 34'(p2_c_reg);
        xx = 34'(p2_t_reg[0]);
        yy = 34'(p2_t_reg[1]);
        zz = 34'(p2_t_reg[2]);
        xy = 34'(p2_t_reg[3]);
        xz = 34'(p2_t_reg[4]);
        yz = 34'(p2_t_reg[5]);
        xs = 34'(p2_us_reg[0]);
        ys = 34'(p2_us_reg[1]);
        zs = 34'(p2_us_reg[2]);
        if (p2_zero_reg)
        begin
            for (int j = 0; j < 9; j++)
                m_reg[j] <= (j % 4 == 0) ? aarm_pkg::OUT_ONE : 16'sd0;
        end
        else
        begin
            m_reg[0] <= aarm_pkg::to_out(c + xx);
            m_reg[1] <= aarm_pkg::to_out(xy + zs);
            m_reg[2] <= aarm_pkg::to_out(xz - ys);
            m_reg[3] <= aarm_pkg::to_out(xy - zs);
            m_reg[4] <= aarm_pkg::to_out(c + yy);
            m_reg[5] <= aarm_pkg::to_out(yz + xs);
            m_reg[6] <= aarm_pkg::to_out(xz + ys);
            m_reg[7] <= aarm_pkg::to_out(yz - xs);
            m_reg[8] <= aarm_pkg::to_out(c + zz);
        end
    end

    assign done = done_reg;
    assign m00  = m_reg[0];
    assign m01  = m_reg[1];
    assign m02  = m_reg[2];
    assign m10  = m_reg[3];
    assign m11  = m_reg[4];
    assign m12  = m_reg[5];
    assign m20  = m_reg[6];
    assign m21  = m_reg[7];
    assign m22  = m_reg[8];

    // every result traces back to a request a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, aarm_pkg::TOTAL_LAT))
        else $error("result without matching request");

    // CORDIC and normalizer branches stay aligned
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        norm_out.valid |-> $past(cord_out.valid, D))
        else $error("cos/sin delay out of step with normalizer");

    // diagonal stays within plus or minus one
    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (m00 <= aarm_pkg::OUT_ONE && m00 >= -aarm_pkg::OUT_ONE
               && m11 <= aarm_pkg::OUT_ONE && m11 >= -aarm_pkg::OUT_ONE
               && m22 <= aarm_pkg::OUT_ONE && m22 >= -aarm_pkg::OUT_ONE))
        else $error("diagonal element out of range");

endmodule

@@ test/tb_axis_angle_rotation_matrix_core.sv @@
// Testbench for the axis-angle rotation matrix core: scoreboard with a fixed-point predictor.
`timescale 1ns / 1ps

typedef struct {
    logic signed [15:0] m [9];
} rot_matrix_t;

class rotation_scoreboard;
    rot_matrix_t pending[$];
    int          mismatches;

    function new();
        mismatches = 0;
    endfunction

    // arithmetic shift right, floor
    static function longint sar(longint v, int n);
        return v >>> n;
    endfunction

    static function longint mulq(longint p, longint q);
        return (p * q) >>> 28;
    endfunction

    static function logic signed [15:0] round_clamp(longint v);
        longint o;
        o = (v + 64'sd8192) >>> 14;
        if (o > 16384)
            o = 16384;
        if (o < -16384)
            o = -16384;
        return 16'(o);
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    static function longint unit_part(longint a, longint unsigned r);
        longint unsigned mag, q;
        mag = (a < 0) ? -a : a;
        q = ((mag << 44) + (r >> 1)) / r;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    static function longint atan_step(int i);
        longint tbl[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                            8385879, 4193963, 2097109, 1048571, 524287};
        if (i < 10)
            return tbl[i];
        return (i < 29) ? (64'sd1 <<< (28 - i)) : 0;
    endfunction

    // expected matrix for one request
    static function rot_matrix_t rodrigues(logic signed [14:0] ang, logic signed [15:0] ax,
                                           logic signed [15:0] ay, logic signed [15:0] az);
        rot_matrix_t     res;
        longint          x, y, z, cx, sy, zz, c, s, omc, ux, uy, uz, xy, xz, yz, dx, dy;
        longint unsigned l2, r;
        bit              flip;
        ux = ax;
        uy = ay;
        uz = az;
        l2 = ux * ux + uy * uy + uz * uz;
        if (l2 == 0)
        begin
            foreach (res.m[k])
                res.m[k] = (k % 4 == 0) ? 16'sd16384 : 16'sd0;
            return res;
        end
        r = int_sqrt(l2 << 32);
        x = unit_part(ux, r);
        y = unit_part(uy, r);
        z = unit_part(uz, r);
        // quadrant fold, then CORDIC rotation
        zz = longint'(ang) * 65536;
        flip = 0;
        if (zz > 421657428)
        begin
            zz = zz - 843314857;
            flip = 1;
        end
        else if (zz < -421657428)
        begin
            zz = zz + 843314857;
            flip = 1;
        end
        cx = 163008218;
        sy = 0;
        for (int i = 0; i < aarm_pkg::CORDIC_STEPS; i++)
        begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (zz >= 0)
            begin
                cx = cx - dx;
                sy = sy + dy;
                zz = zz - atan_step(i);
            end
            else
            begin
                cx = cx + dx;
                sy = sy - dy;
                zz = zz + atan_step(i);
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -sy : sy;
        omc = (64'sd1 <<< 28) - c;
        xy = mulq(mulq(x, y), omc);
        xz = mulq(mulq(x, z), omc);
        yz = mulq(mulq(y, z), omc);
        res.m[0] = round_clamp(c + mulq(mulq(x, x), omc));
        res.m[1] = round_clamp(xy + mulq(z, s));
        res.m[2] = round_clamp(xz - mulq(y, s));
        res.m[3] = round_clamp(xy - mulq(z, s));
        res.m[4] = round_clamp(c + mulq(mulq(y, y), omc));
        res.m[5] = round_clamp(yz + mulq(x, s));
        res.m[6] = round_clamp(xz + mulq(y, s));
        res.m[7] = round_clamp(yz - mulq(x, s));
        res.m[8] = round_clamp(c + mulq(mulq(z, z), omc));
        return res;
    endfunction

    function void note_request(logic signed [14:0] ang, logic signed [15:0] ax,
                               logic signed [15:0] ay, logic signed [15:0] az);
        pending.push_back(rodrigues(ang, ax, ay, az));
    endfunction

    function void check_matrix(rot_matrix_t got);
        rot_matrix_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result with no request outstanding");
            return;
        end
        want = pending.pop_front();
        foreach (want.m[k])
            if (got.m[k] !== want.m[k])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("element %0d%0d: expected %0d, got %0d",
                             k / 3, k % 3, want.m[k], got.m[k]);
            end
    endfunction
endclass

module tb_axis_angle_rotation_matrix_core;

    localparam int N_RANDOM    = 1200;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [14:0] angle;
    logic signed [15:0] axis_x, axis_y, axis_z;
    logic               done;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    rotation_scoreboard board;
    int                 cycles;

    axis_angle_rotation_matrix_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
        .done(done),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
        .m12(m12), .m20(m20), .m21(m21), .m22(m22)
    );

    initial
    begin
        clk = 0;
        board = new();
    end

    always #5 clk = ~clk;

    // accepted requests and results, sampled at the edge
    always @(posedge clk)
    begin
        rot_matrix_t got;
        if (rst_n && start && !busy)
            board.note_request(angle, axis_x, axis_y, axis_z);
        if (rst_n && done)
        begin
            got.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            board.check_matrix(got);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_axis_angle_rotation_matrix_core: errors");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [14:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 15'sd12868;
            1: return -15'sd12868;
            2: return 15'($urandom);   // beyond +-pi too
            default: return 15'(int'($urandom_range(0, 25736)) - 12868);
        endcase
    endfunction

    // one request, held until accepted, then a random gap
    task automatic send_request(logic signed [14:0] a, logic signed [15:0] x,
                                logic signed [15:0] y, logic signed [15:0] z);
        int gap;
        start  <= 1'b1;
        angle  <= a;
        axis_x <= x;
        axis_y <= y;
        axis_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (aarm_pkg::TOTAL_LAT + 10) @(posedge clk);
    endtask

    initial
    begin
        cycles = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        angle  = '0;
        axis_x = '0;
        axis_y = '0;
        axis_z = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero axis, principal axes, angles beyond pi
        send_request(15'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_request(15'sd12868, 16'sd0, 16'sd0, 16'sd0);
        send_request(15'sd6434, 16'sd1, 16'sd0, 16'sd0);
        send_request(15'sd6434, 16'sd0, 16'sd1, 16'sd0);
        send_request(15'sd6434, 16'sd0, 16'sd0, 16'sd1);
        send_request(15'sd12868, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_request(-15'sd12868, 16'sh8000, 16'sh8000, 16'sh8000);
        send_request(15'sh3fff, 16'sh8000, 16'sh7fff, 16'sd1);
        send_request(15'sh4000, -16'sd1, 16'sd0, 16'sh7fff);
        send_request(15'sd0, 16'sd3, -16'sd4, 16'sd12);
        send_request(15'sd3217, 16'sd1, 16'sd1, 16'sd1);
        send_request(-15'sd3217, -16'sd1, 16'sd2, -16'sd3);
        send_request(15'sd12867, 16'sd0, 16'sh8000, 16'sd0);
        send_request(-15'sd1, 16'sd100, 16'sd0, -16'sd100);
        send_request(15'sd1, 16'sh5555, 16'shaaaa, 16'sh00ff);

        // full drain once mid-run
        drain_results();

        for (int n = 0; n < N_RANDOM; n++)
            send_request(rand_angle(), rand_axis(), rand_axis(), rand_axis());

        drain_results();
        if (board.mismatches == 0)
            $display("tb_axis_angle_rotation_matrix_core: clean");
        else
            $display("tb_axis_angle_rotation_matrix_core: errors");
        $finish;
    end
endmodule
